// ----- src/srws_pkg.sv -----
// Shared types and constants for the scan range window smoother.
// Used by srws_ctrl, srws_dpath and scan_range_window_smoother_top; no dependencies.
package srws_pkg;

   localparam int unsigned FIELD_W = 16;

   typedef struct packed {
      logic shift;
      logic take_in;
      logic div_load;
      logic out_load;
      logic last_mark;
      logic clear;
   } srws_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic out_full;
   } srws_stat_type;

endpackage

// ----- src/srws_ctrl.sv -----
// Sequencer for the window smoother: sample intake, scan-end flush and result hand-off.
// Depends on srws_pkg; drives srws_dpath through command and status structs.
module srws_ctrl #(
   parameter int unsigned HALF_SPAN = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tlast,
   output logic                  req_tready,
   output srws_pkg::srws_cmd_type  cmd,
   input  srws_pkg::srws_stat_type stat
);
   import srws_pkg::*;

   localparam int unsigned SEEN_W = $clog2(HALF_SPAN + 1);
   localparam int unsigned FW     = $clog2(HALF_SPAN + 2);
   localparam int unsigned CMP_W  = FW + 1;
   localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(HALF_SPAN);
   localparam logic [FW-1:0]     STEP_MAX = FW'(HALF_SPAN);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FLUSH = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [FW-1:0]     fstep_ff, fstep_in;
   logic              last_ff, last_in;
   logic              final_ff, final_in;
   logic              flush_emit;

   assign flush_emit = (CMP_W'(fstep_ff) + CMP_W'(seen_ff)) > CMP_W'(HALF_SPAN);

   always_comb begin
      state_in   = state_ff;
      seen_in    = seen_ff;
      fstep_in   = fstep_ff;
      last_in    = last_ff;
      final_in   = final_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.shift   = 1'b1;
               cmd.take_in = 1'b1;
               last_in     = req_tlast;
               fstep_in    = FW'(1);
               if (seen_ff == SEEN_MAX) begin
                  cmd.div_load = 1'b1;
                  final_in     = 1'b0;
                  state_in     = ST_DIV;
               end else begin
                  seen_in = seen_ff + 1'b1;
                  if (req_tlast) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            cmd.shift = 1'b1;
            fstep_in  = fstep_ff + 1'b1;
            if (flush_emit) begin
               cmd.div_load = 1'b1;
               final_in     = (fstep_ff == STEP_MAX);
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!stat.div_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!stat.out_full) begin
               cmd.out_load  = 1'b1;
               cmd.last_mark = final_ff;
               if (final_ff) begin
                  cmd.clear = 1'b1;
                  seen_in   = '0;
                  last_in   = 1'b0;
                  final_in  = 1'b0;
                  state_in  = ST_IDLE;
               end else if (last_ff) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= '0;
         fstep_ff <= '0;
         last_ff  <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
         fstep_ff <= fstep_in;
         last_ff  <= last_in;
         final_ff <= final_in;
      end
   end

endmodule

// ----- src/srws_dpath.sv -----
// Datapath of the window smoother: sample window with running sum and count,
// radix-16 restoring divider and output register. Depends on srws_pkg.
module srws_dpath #(
   parameter int unsigned HALF_SPAN  = 2,
   parameter int unsigned RANGE_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  srws_pkg::srws_cmd_type         cmd,
   output srws_pkg::srws_stat_type        stat,
   input  logic [srws_pkg::FIELD_W-1:0]   in_range,
   input  logic                           in_ok,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [srws_pkg::FIELD_W-1:0]   rsp_tdata,
   output logic                           rsp_tuser,
   output logic                           rsp_tlast
);
   import srws_pkg::*;

   localparam int unsigned WIN_LEN  = 2 * HALF_SPAN + 1;
   localparam int unsigned RW       = (RANGE_BITS < FIELD_W) ? RANGE_BITS : FIELD_W;
   localparam int unsigned CW       = $clog2(WIN_LEN + 1);
   localparam int unsigned SW       = RW + $clog2(WIN_LEN);
   localparam int unsigned DIV_BITS = 4;
   localparam int unsigned DW       = ((SW + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
   localparam int unsigned NSTEP    = DW / DIV_BITS;
   localparam int unsigned NW       = $clog2(NSTEP + 1);

   logic [RW-1:0]      win_r_ff [WIN_LEN];
   logic [WIN_LEN-1:0] win_v_ff;
   logic [SW-1:0]      sum_ff, sum_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [RW-1:0]      new_r;
   logic               new_v;
   logic [SW-1:0]      old_term, new_term;

   logic [DW-1:0]      dvd_ff, dvd_in;
   logic [DW-1:0]      quo_ff, quo_in;
   logic [CW-1:0]      rem_ff, rem_in;
   logic [CW-1:0]      dvs_ff;
   logic [NW-1:0]      steps_ff;
   logic [RW-1:0]      raw_ff;
   logic               any_ok_ff;

   logic               out_valid_ff;
   logic [FIELD_W-1:0] out_data_ff;
   logic               out_ok_ff;
   logic               out_last_ff;

   assign new_r    = cmd.take_in ? in_range[RW-1:0] : '0;
   assign new_v    = cmd.take_in & in_ok;
   assign old_term = win_v_ff[0] ? SW'(win_r_ff[0]) : '0;
   assign new_term = new_v ? SW'(new_r) : '0;
   assign sum_in   = sum_ff - old_term + new_term;
   assign cnt_in   = cnt_ff - CW'(win_v_ff[0]) + CW'(new_v);

   always_comb begin
      logic [CW:0] trial;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      for (int j = 0; j < DIV_BITS; j++) begin
         trial  = {rem_in, dvd_in[DW-1]};
         dvd_in = {dvd_in[DW-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CW'(trial - {1'b0, dvs_ff});
            quo_in = {quo_in[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[CW-1:0];
            quo_in = {quo_in[DW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_v_ff     <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         steps_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            win_v_ff <= '0;
            sum_ff   <= '0;
            cnt_ff   <= '0;
         end else if (cmd.shift) begin
            win_v_ff <= {new_v, win_v_ff[WIN_LEN-1:1]};
            sum_ff   <= sum_in;
            cnt_ff   <= cnt_in;
         end
         if (cmd.div_load) begin
            steps_ff <= NW'(NSTEP);
         end else if (steps_ff != '0) begin
            steps_ff <= steps_ff - 1'b1;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         for (int k = 0; k < WIN_LEN - 1; k++) begin
            win_r_ff[k] <= win_r_ff[k+1];
         end
         win_r_ff[WIN_LEN-1] <= new_r;
      end
      if (cmd.div_load) begin
         dvd_ff    <= DW'(sum_in);
         dvs_ff    <= cnt_in;
         rem_ff    <= '0;
         raw_ff    <= win_r_ff[HALF_SPAN+1];
         any_ok_ff <= (cnt_in != '0);
      end else if (steps_ff != '0) begin
         dvd_ff <= dvd_in;
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.out_load) begin
         out_data_ff <= any_ok_ff ? FIELD_W'(quo_ff[RW-1:0]) : FIELD_W'(raw_ff);
         out_ok_ff   <= any_ok_ff;
         out_last_ff <= cmd.last_mark;
      end
   end

   assign stat.div_busy = (steps_ff != '0);
   assign stat.out_full = out_valid_ff & ~rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_ok_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- src/scan_range_window_smoother_top.sv -----
// Channel  | Signals                   | Word contents
// req      | req_tvalid/tready         | tdata: range_mm; tuser: sample_ok; tlast: scan_end
// rsp      | rsp_tvalid/tready         | tdata: smoothed_mm; tuser: smoothed_ok;
//          |                           | tlast: final_of_scan
// Top level of the scan range window smoother; depends on srws_pkg, srws_ctrl, srws_dpath.
// A word that emits a result passes through intake, the radix-16 divider steps and the load
// of the output register; a word that emits nothing is only taken into the window.
// The final word of a scan adds HALF_SPAN flush shifts, each followed by a divide when
// it emits. The divider paces the block. Reset is synchronous and clears the window.
// A stalled output holds the output register; intake continues until the next result
// needs that register.
module scan_range_window_smoother_top #(
   parameter int unsigned HALF_SPAN  = 2,
   parameter int unsigned RANGE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [srws_pkg::FIELD_W-1:0] req_tdata,  // [15:0] range_mm
   input  logic                         req_tuser,  // [0] sample_ok
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [srws_pkg::FIELD_W-1:0] rsp_tdata,  // [15:0] smoothed_mm
   output logic                         rsp_tuser,  // [0] smoothed_ok
   output logic                         rsp_tlast
);
   import srws_pkg::*;

   srws_cmd_type  cmd;
   srws_stat_type stat;

   srws_ctrl #(
      .HALF_SPAN(HALF_SPAN)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   srws_dpath #(
      .HALF_SPAN  (HALF_SPAN),
      .RANGE_BITS (RANGE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_range   (req_tdata),
      .in_ok      (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- bench/tb_scan_range_window_smoother_top.sv -----
// Self-checking bench for scan_range_window_smoother_top: drives range words with random
// gaps and output stalls, and predicts the centered window means in a scoreboard class.
// Depends on srws_pkg and the smoother RTL.
module tb_scan_range_window_smoother_top;

   localparam int HALF_W = 2;
   localparam int WIN_LEN = 2 * HALF_W + 1;
   localparam int RNG_W = srws_pkg::FIELD_W;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [RNG_W-1:0] mm;
      logic             ok;
      logic             fin;
   } smooth_word_type;

   class smooth_scoreboard_type;
      logic [RNG_W-1:0] win_rng[WIN_LEN];
      bit               win_ok[WIN_LEN];
      int               pend_cnt;
      smooth_word_type  smoothed_q[$];
      int unsigned      mismatches;
      int unsigned      words_in;
      int unsigned      scans_done;
      int unsigned      results_seen;
      int unsigned      empty_windows;

      function new();
         clear_window();
      endfunction

      function void clear_window();
         foreach (win_rng[k]) begin
            win_rng[k] = '0;
            win_ok[k]  = 1'b0;
         end
         pend_cnt = 0;
      endfunction

      function void shift_window(logic [RNG_W-1:0] rng, bit ok);
         for (int k = 0; k < WIN_LEN - 1; k++) begin
            win_rng[k] = win_rng[k+1];
            win_ok[k]  = win_ok[k+1];
         end
         win_rng[WIN_LEN-1] = rng;
         win_ok[WIN_LEN-1]  = ok;
      endfunction

      function void emit_centre(bit fin);
         int unsigned     total;
         int unsigned     hits;
         smooth_word_type res;
         total = 0;
         hits  = 0;
         for (int k = 0; k < WIN_LEN; k++) begin
            if (win_ok[k]) begin
               total += win_rng[k];
               hits++;
            end
         end
         if (hits > 0) begin
            res.mm = RNG_W'(total / hits);
            res.ok = 1'b1;
         end else begin
            res.mm = win_rng[HALF_W];
            res.ok = 1'b0;
            empty_windows++;
         end
         res.fin = fin;
         smoothed_q = {smoothed_q, res};
      endfunction

      function void note_sample(logic [RNG_W-1:0] rng, bit ok, bit last);
         int first;
         words_in++;
         shift_window(rng, ok);
         if (pend_cnt < HALF_W) begin
            pend_cnt++;
         end else begin
            emit_centre(1'b0);
         end
         if (last) begin
            first = HALF_W - pend_cnt + 1;
            for (int s = 1; s <= HALF_W; s++) begin
               shift_window('0, 1'b0);
               if (s >= first) begin
                  emit_centre(s == HALF_W);
               end
            end
            scans_done++;
            clear_window();
         end
      endfunction

      function void check_result(logic [RNG_W-1:0] mm, logic ok, logic fin);
         smooth_word_type want;
         results_seen++;
         if (smoothed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: unexpected result mm=%0d ok=%0b last=%0b", mm, ok, fin);
            end
            return;
         end
         want = smoothed_q.pop_front();
         if (mm !== want.mm || ok !== want.ok || fin !== want.fin) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: result %0d expected mm=%0d ok=%0b last=%0b, got mm=%0d ok=%0b last=%0b",
                        results_seen, want.mm, want.ok, want.fin, mm, ok, fin);
            end
         end
      endfunction

      function int unsigned pending();
         return smoothed_q.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [RNG_W-1:0] req_tdata;
   logic             req_tuser;
   logic             req_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RNG_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             rsp_tlast;

   smooth_scoreboard_type sb;
   bit                    src_calm;
   bit                    dst_calm;

   scan_range_window_smoother_top #(
      .HALF_SPAN  (HALF_W),
      .RANGE_BITS (16)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic send_word(input logic [RNG_W-1:0] rng, input logic ok, input logic last);
      int gap;
      if ($urandom_range(0, 24) == 0) begin
         src_calm = ~src_calm;
      end
      gap = src_calm ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= rng;
      req_tuser  <= ok;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(rng, ok, last);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [RNG_W-1:0] pick_range();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return RNG_W'($urandom_range(0, 15));
         default: return RNG_W'($urandom());
      endcase
   endfunction

   task automatic send_random_scan(input int len, input int ok_pct);
      for (int i = 0; i < len; i++) begin
         send_word(pick_range(), $urandom_range(0, 99) < ok_pct, i == len - 1);
      end
   endtask

   initial begin
      int len;
      int ok_pct;
      bit paused;
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      src_calm   = 1'b0;
      paused     = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_word(16'hFFFF, 1'b1, 1'b1);
      send_word(16'd1234, 1'b0, 1'b1);
      send_word(16'h0000, 1'b1, 1'b0);
      send_word(16'hFFFF, 1'b1, 1'b1);
      send_word(16'h00FF, 1'b0, 1'b0);
      send_word(16'hFF00, 1'b1, 1'b0);
      send_word(16'h5555, 1'b0, 1'b1);
      send_word(16'hAAAA, 1'b0, 1'b0);
      send_word(16'h0001, 1'b0, 1'b0);
      send_word(16'hFFFE, 1'b0, 1'b0);
      send_word(16'h8000, 1'b0, 1'b0);
      send_word(16'h7FFF, 1'b0, 1'b1);
      send_word(16'hFFFF, 1'b1, 1'b0);
      send_word(16'hFFFF, 1'b1, 1'b0);
      send_word(16'hFFFF, 1'b1, 1'b0);
      send_word(16'hFFFF, 1'b1, 1'b0);
      send_word(16'hFFFF, 1'b1, 1'b0);
      send_word(16'h0000, 1'b0, 1'b0);
      send_word(16'h0001, 1'b1, 1'b0);
      send_word(16'h0002, 1'b1, 1'b0);
      send_word(16'h0003, 1'b0, 1'b0);
      send_word(16'h0000, 1'b0, 1'b1);
      hold_until_drained();

      while (sb.words_in < 190) begin
         case ($urandom_range(0, 9))
            0:       len = $urandom_range(1, HALF_W + 1);
            1:       len = $urandom_range(20, 32);
            default: len = $urandom_range(3, 12);
         endcase
         case ($urandom_range(0, 5))
            0:       ok_pct = 0;
            1:       ok_pct = 100;
            2:       ok_pct = 30;
            default: ok_pct = 80;
         endcase
         send_random_scan(len, ok_pct);
         if (!paused && sb.words_in > 120) begin
            hold_until_drained();
            paused = 1'b1;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Summary: %0d words in %0d scans, %0d results checked, %0d with an empty window",
               sb.words_in, sb.scans_done, sb.results_seen, sb.empty_windows);
      $display("Mismatches: %0d, results still owed: %0d", sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      int stall;
      rsp_tready = 1'b0;
      dst_calm   = 1'b0;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         if ($urandom_range(0, 19) == 0) begin
            dst_calm = ~dst_calm;
         end
         stall = dst_calm ? 0 : $urandom_range(0, 15);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   initial begin
      #3000000;
      $display("Timeout: %0d results still owed", sb.pending());
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- scan_range_window_smoother_top.f -----
src/srws_pkg.sv
src/srws_ctrl.sv
src/srws_dpath.sv
src/scan_range_window_smoother_top.sv
bench/tb_scan_range_window_smoother_top.sv
